// ===== rtl/core/ssfs_pkg.sv =====
// Shared types and constants for the sticky saturating frame summer.
`timescale 1ns / 1ps

package ssfs_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_UNDERLOAD = 2'd0;
  localparam logic [1:0] CFG_OVERLOAD  = 2'd1;
  localparam logic [1:0] CFG_UNSIGNED  = 2'd2;

  // Item actions
  localparam logic ACT_ACCUM   = 1'b0;
  localparam logic ACT_READOUT = 1'b1;

  // Queue depths between the parts
  localparam int QUE_DEPTH = 4;
  localparam int RES_DEPTH = 4;
  localparam int RES_LVL_W = $clog2(RES_DEPTH + 1);

  // Sample limits for the sticky markers
  localparam int SAMPLE_UNDER_LIM = -32764;
  localparam int SAMPLE_OVER_LIM  = 32763;
  localparam logic [31:0] PREVIEW_MAX = 32'sd32767;
  localparam logic [31:0] PREVIEW_MIN = -32'sd32768;
  localparam logic [31:0] SUM_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SUM_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] underload_code;
    logic [31:0] overload_code;
    logic        unsigned_mode;
  } cfg_t;

  typedef struct packed {
    logic [31:0] sum_value;
    logic [15:0] preview_value;
  } res_t;

endpackage

// ===== rtl/core/sticky_saturating_frame_summer.sv =====
// Top level: per-pixel frame summer with sticky saturation markers.
// Item path: front register, work queue, update stage, result queue. Throughput:
// one item per cycle while work is queued and results have room, set by the single
// read-modify-write of the sum store (registered read, next-cycle write, same-address
// bypass). Reset: synchronous, active low; afterwards a clearing pass zeroes all DEPTH
// entries of the store, with in_full high; configuration writes are taken throughout.
`timescale 1ns / 1ps

module sticky_saturating_frame_summer import ssfs_pkg::*; #(
  parameter int PIXELS_PER_MODULE = 524288,
  parameter int MODULES           = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_action,
  input  logic               in_module_req,
  input  logic [18:0]        in_pixel_index,
  input  logic [15:0]        in_sample,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_sum_value,
  output logic signed [15:0] out_preview_value,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int DEPTH   = MODULES * PIXELS_PER_MODULE;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ENTRY_W = AW + 18;

  cfg_t                 cfg_r;
  logic                 busy;
  logic                 q_push, q_pop, q_full, q_empty;
  logic [ENTRY_W-1:0]   q_wdata, q_rdata;
  logic [$clog2(QUE_DEPTH+1)-1:0] q_level;
  logic                 res_push, res_full;
  res_t                 res_wdata, res_rdata;
  logic [RES_LVL_W-1:0] res_level;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.underload_code <= SUM_MIN;
      cfg_r.overload_code  <= SUM_MAX;
      cfg_r.unsigned_mode  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UNDERLOAD: cfg_r.underload_code <= cfg_data;
        CFG_OVERLOAD:  cfg_r.overload_code  <= cfg_data;
        CFG_UNSIGNED:  cfg_r.unsigned_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ssfs_front #(
    .MODULES           (MODULES),
    .PIXELS_PER_MODULE (PIXELS_PER_MODULE),
    .AW                (AW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .busy           (busy),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_action      (in_action),
    .in_module_req  (in_module_req),
    .in_pixel_index (in_pixel_index),
    .in_sample      (in_sample),
    .q_push         (q_push),
    .q_data         (q_wdata),
    .q_full         (q_full)
  );

  ssfs_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUE_DEPTH)
  ) u_work_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wdata),
    .pop     (q_pop),
    .rd_data (q_rdata),
    .full    (q_full),
    .empty   (q_empty),
    .level   (q_level)
  );

  ssfs_back #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .busy      (busy),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .res_level (res_level),
    .res_push  (res_push),
    .res_data  (res_wdata)
  );

  ssfs_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_wdata),
    .pop     (out_pop && !out_empty),
    .rd_data (res_rdata),
    .full    (res_full),
    .empty   (out_empty),
    .level   (res_level)
  );

  assign out_sum_value     = res_rdata.sum_value;
  assign out_preview_value = res_rdata.preview_value;

  function automatic logic q_data_is_read(input logic [ENTRY_W-1:0] d);
    q_data_is_read = d[ENTRY_W-1];
  endfunction

  // Hold the input side closed while the store is being cleared
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> in_full)
    else $error("item input open during clearing pass");

  // Credit check must keep the result queue from overflowing
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result queue overflow");

  // Front must not push into a full work queue
  a_work_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (!q_full && q_level < ($clog2(QUE_DEPTH+1))'(QUE_DEPTH)))
    else $error("work queue overflow");

  // Update stage only runs after a pop from the work queue
  a_stage_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (res_push == $past(q_data_is_read(q_rdata))))
    else $error("update stage lost an item");

endmodule

// ===== rtl/core/ssfs_fifo.sv =====
// Small register queue used between the front, the back and the result port.
`timescale 1ns / 1ps

module ssfs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wr_data,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rd_data,
  output logic                         full,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   level
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0]    cnt_r, cnt_nxt;

  assign full    = (cnt_r == LW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign level   = cnt_r;
  assign rd_data = slot_r[rd_ptr_r];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/core/ssfs_front.sv =====
// Front end: accept items, check the pixel address and queue the work.
`timescale 1ns / 1ps

module ssfs_front import ssfs_pkg::*; #(
  parameter int MODULES           = 2,
  parameter int PIXELS_PER_MODULE = 524288,
  parameter int AW                = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                busy,
  input  logic                in_push,
  output logic                in_full,
  input  logic                in_action,
  input  logic                in_module_req,
  input  logic [18:0]         in_pixel_index,
  input  logic [15:0]         in_sample,
  output logic                q_push,
  output logic [AW+17:0]      q_data,
  input  logic                q_full
);

  typedef struct packed {
    logic          is_read;
    logic          zero;
    logic [AW-1:0] addr;
    logic [15:0]   sample;
  } entry_t;

  localparam logic [31:0] PPM_W = 32'(PIXELS_PER_MODULE);
  localparam logic [31:0] MOD_W = 32'(MODULES);

  logic   f_valid_r;
  entry_t f_entry_r;
  entry_t cls;
  logic   addr_ok;
  logic   keep;

  // Classify the incoming item
  always_comb begin
    addr_ok     = (32'(in_module_req) < MOD_W) && ({13'd0, in_pixel_index} < PPM_W);
    cls.is_read = (in_action == ACT_READOUT);
    cls.zero    = !addr_ok;
    cls.addr    = AW'(in_pixel_index) + (in_module_req ? AW'(PIXELS_PER_MODULE) : '0);
    cls.sample  = in_sample;
    // An accumulate outside the store does nothing; drop it here
    keep        = addr_ok || cls.is_read;
  end

  assign in_full = busy || (f_valid_r && q_full);
  assign q_push  = f_valid_r && !q_full;
  assign q_data  = f_entry_r;

  // Hold the classified item until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (!in_full) begin
      f_valid_r <= in_push && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_full && in_push) begin
      f_entry_r <= cls;
    end
  end

endmodule

// ===== rtl/core/ssfs_back.sv =====
// Back end: sum store, clearing pass and read-modify-write with bypass.
`timescale 1ns / 1ps

module ssfs_back import ssfs_pkg::*; #(
  parameter int DEPTH = 1048576,
  parameter int AW    = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  output logic                  busy,
  input  logic                  q_empty,
  input  logic [AW+17:0]        q_data,
  output logic                  q_pop,
  input  logic [RES_LVL_W-1:0]  res_level,
  output logic                  res_push,
  output res_t                  res_data
);

  typedef struct packed {
    logic          is_read;
    logic          zero;
    logic [AW-1:0] addr;
    logic [15:0]   sample;
  } entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  logic [31:0]   sums [DEPTH];
  logic [31:0]   mem_q_r;
  logic          fwd_hit_r;
  logic [31:0]   fwd_data_r;

  entry_t        q_entry;
  logic          b_valid_r;
  entry_t        b_entry_r;

  logic          room;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;

  logic [31:0]   cur;
  logic [16:0]   smp;
  logic          under, over;
  logic [32:0]   sum33;
  logic [31:0]   sat;
  logic [31:0]   upd;
  logic [15:0]   prev;

  assign q_entry = q_data;
  assign busy    = (state_r == ST_CLEAR);

  // Take the next item only if its result is sure of a place
  assign room  = ({1'b0, res_level} + {{RES_LVL_W{1'b0}}, (b_valid_r && b_entry_r.is_read)})
               < (RES_LVL_W + 1)'(RES_DEPTH);
  assign q_pop = !busy && !q_empty && room;

  // Clearing pass over the store after reset
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Current sum: bypass the write that lands on the same edge as the read
  always_comb begin
    if (b_entry_r.zero) begin
      cur = '0;
    end else if (fwd_hit_r) begin
      cur = fwd_data_r;
    end else begin
      cur = mem_q_r;
    end
  end

  // Sticky marker and saturating sum update
  always_comb begin
    smp   = cfg.unsigned_mode ? {1'b0, b_entry_r.sample}
                              : {b_entry_r.sample[15], b_entry_r.sample};
    under = !cfg.unsigned_mode && ($signed(smp) < SAMPLE_UNDER_LIM);
    over  = $signed(smp) > SAMPLE_OVER_LIM;
    sum33 = {cur[31], cur} + {{16{smp[16]}}, smp};
    if (sum33[32] != sum33[31]) begin
      sat = sum33[32] ? SUM_MIN : SUM_MAX;
    end else begin
      sat = sum33[31:0];
    end
    priority if (!cfg.unsigned_mode && (under || cur == cfg.underload_code)) begin
      upd = cfg.underload_code;
    end else if (over || cur == cfg.overload_code) begin
      upd = cfg.overload_code;
    end else begin
      upd = sat;
    end
  end

  // Clamp the sum for the preview
  always_comb begin
    priority if ($signed(cur) >= $signed(PREVIEW_MAX)) begin
      prev = PREVIEW_MAX[15:0];
    end else if ($signed(cur) <= $signed(PREVIEW_MIN)) begin
      prev = PREVIEW_MIN[15:0];
    end else begin
      prev = cur[15:0];
    end
  end

  // Write port: clearing pass, then the item in the update stage
  always_comb begin
    if (busy) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else begin
      wr_en   = b_valid_r && !b_entry_r.zero;
      wr_addr = b_entry_r.addr;
      wr_data = b_entry_r.is_read ? '0 : upd;
    end
  end

  assign res_push               = b_valid_r && b_entry_r.is_read;
  assign res_data.sum_value     = cur;
  assign res_data.preview_value = prev;

  // Sum store with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      sums[wr_addr] <= wr_data;
    end
    if (q_pop) begin
      mem_q_r <= sums[q_entry.addr];
    end
  end

  // Capture bypass data and advance the update stage
  always_ff @(posedge clk) begin
    fwd_data_r <= wr_data;
    if (q_pop) begin
      b_entry_r <= q_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      b_valid_r <= q_pop;
      fwd_hit_r <= q_pop && wr_en && (wr_addr == q_entry.addr);
    end
  end

endmodule

// ===== tb/sticky_saturating_frame_summer_test.sv =====
// Self-checking testbench for the sticky saturating frame summer.
`timescale 1ns / 1ps

module sticky_saturating_frame_summer_test;
  import ssfs_pkg::*;

  localparam int PIX_PER_MOD = 524288;
  localparam int MOD_COUNT   = 2;
  // Cycles after the last result before the pipe, input queue included, is surely empty
  localparam int SETTLE_CYCLES = 12;
  // Several times the clearing pass after reset, the longest quiet stretch of a good run
  localparam int STALL_LIMIT = 4 * MOD_COUNT * PIX_PER_MOD;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 140;
  localparam longint SUM_HI = 64'sd2147483647;
  localparam longint SUM_LO = -64'sd2147483648;

  typedef struct packed {
    logic        action;
    logic        mod_sel;
    logic [18:0] pixel;
    logic [15:0] sample;
    logic        typed;
    logic [31:0] exp_sum;
    logic [15:0] exp_prev;
  } dir_row_t;

  // Directed items; typed expectations only where the answer is obvious
  localparam dir_row_t DIRECTED_ROWS [26] = '{
    '{ACT_READOUT, 1'b0, 19'h00000, 16'h0000, 1'b1, 32'h0000_0000, 16'h0000},
    '{ACT_READOUT, 1'b1, 19'h7FFFF, 16'hFFFF, 1'b1, 32'h0000_0000, 16'h0000},
    '{ACT_ACCUM,   1'b0, 19'h00005, 16'h7FFC, 1'b0, 32'h0, 16'h0},
    '{ACT_READOUT, 1'b0, 19'h00005, 16'h0000, 1'b1, 32'h7FFF_FFFF, 16'h7FFF},
    '{ACT_ACCUM,   1'b0, 19'h00006, 16'h8003, 1'b0, 32'h0, 16'h0},
    '{ACT_READOUT, 1'b0, 19'h00006, 16'h0000, 1'b1, 32'h8000_0000, 16'h8000},
    '{ACT_ACCUM,   1'b0, 19'h00007, 16'h7FFB, 1'b0, 32'h0, 16'h0},
    '{ACT_ACCUM,   1'b0, 19'h00007, 16'h8004, 1'b0, 32'h0, 16'h0},
    '{ACT_READOUT, 1'b0, 19'h00007, 16'h0000, 1'b0, 32'h0, 16'h0},
    '{ACT_ACCUM,   1'b1, 19'h00000, 16'h8000, 1'b0, 32'h0, 16'h0},
    '{ACT_ACCUM,   1'b1, 19'h00000, 16'h0001, 1'b0, 32'h0, 16'h0},
    '{ACT_ACCUM,   1'b1, 19'h00000, 16'h7FFF, 1'b0, 32'h0, 16'h0},
    '{ACT_READOUT, 1'b1, 19'h00000, 16'h0000, 1'b1, 32'h8000_0000, 16'h8000},
    '{ACT_ACCUM,   1'b1, 19'h00001, 16'h7FFF, 1'b0, 32'h0, 16'h0},
    '{ACT_ACCUM,   1'b1, 19'h00001, 16'h8000, 1'b0, 32'h0, 16'h0},
    '{ACT_READOUT, 1'b1, 19'h00001, 16'h0000, 1'b0, 32'h0, 16'h0},
    '{ACT_ACCUM,   1'b0, 19'h00000, 16'hFFFF, 1'b0, 32'h0, 16'h0},
    '{ACT_ACCUM,   1'b0, 19'h00000, 16'h0000, 1'b0, 32'h0, 16'h0},
    '{ACT_ACCUM,   1'b0, 19'h00000, 16'h7FFB, 1'b0, 32'h0, 16'h0},
    '{ACT_READOUT, 1'b0, 19'h00000, 16'h0000, 1'b0, 32'h0, 16'h0},
    '{ACT_READOUT, 1'b0, 19'h00000, 16'h0000, 1'b1, 32'h0000_0000, 16'h0000},
    '{ACT_ACCUM,   1'b1, 19'h7FFFF, 16'h0064, 1'b0, 32'h0, 16'h0},
    '{ACT_ACCUM,   1'b1, 19'h7FFFF, 16'h0064, 1'b0, 32'h0, 16'h0},
    '{ACT_READOUT, 1'b1, 19'h7FFFF, 16'hAAAA, 1'b0, 32'h0, 16'h0},
    '{ACT_ACCUM,   1'b0, 19'h2AAAA, 16'h5555, 1'b0, 32'h0, 16'h0},
    '{ACT_READOUT, 1'b0, 19'h2AAAA, 16'h0000, 1'b0, 32'h0, 16'h0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_action = 1'b0;
  logic        in_module_req = 1'b0;
  logic [18:0] in_pixel_index = '0;
  logic [15:0] in_sample = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic signed [31:0] out_sum_value;
  logic signed [15:0] out_preview_value;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_UNDERLOAD;
  logic [31:0] cfg_data = '0;

  // Typed expectation that rides along with a directed item
  logic        row_typed = 1'b0;
  logic [31:0] row_sum = '0;
  logic [15:0] row_prev = '0;

  // Predictor state: register mirror and per-pixel sums (absent entry reads zero)
  logic [31:0] under_code = 32'h8000_0000;
  logic [31:0] over_code  = 32'h7FFF_FFFF;
  logic        mode_unsigned = 1'b0;
  logic [31:0] pixel_sums [int unsigned];
  res_t        pending_readouts [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs = 0;
  int holds_done = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  int mismatches = 0;

  sticky_saturating_frame_summer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_action         (in_action),
    .in_module_req     (in_module_req),
    .in_pixel_index    (in_pixel_index),
    .in_sample         (in_sample),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_sum_value     (out_sum_value),
    .out_preview_value (out_preview_value),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Next sum of a pixel after one accumulated sample
  function automatic logic [31:0] accumulate_sum(logic [31:0] cur, logic [15:0] raw);
    longint smp;
    longint total;
    if (mode_unsigned) smp = longint'({48'b0, raw});
    else smp = longint'($signed(raw));
    if (!mode_unsigned && (smp < SAMPLE_UNDER_LIM || cur == under_code)) return under_code;
    if (smp > SAMPLE_OVER_LIM || cur == over_code) return over_code;
    total = longint'($signed(cur)) + smp;
    if (total > SUM_HI) total = SUM_HI;
    if (total < SUM_LO) total = SUM_LO;
    return total[31:0];
  endfunction

  // Clamp a sum to the signed 16-bit preview range
  function automatic logic [15:0] preview_of(logic [31:0] sum);
    int s;
    s = $signed(sum);
    if (s >= 32767) return 16'h7FFF;
    if (s <= -32768) return 16'h8000;
    return sum[15:0];
  endfunction

  function automatic logic [15:0] pick_sample();
    int r;
    int near_zero;
    r = $urandom_range(99);
    near_zero = int'($urandom_range(4000)) - 2000;
    if (r < 20) return 16'h7FF8 + 16'($urandom_range(15));
    if (r < 35) return ($urandom_range(1) != 0) ? 16'd500 : 16'hFE0C;
    if (r < 75) return near_zero[15:0];
    return 16'($urandom_range(65535));
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
  endtask

  // Predict on accepted items, check accepted results, track stalls
  always @(posedge clk) begin : monitor
    int unsigned addr;
    logic        valid;
    logic [31:0] cur;
    res_t        res;
    logic        moved;
    moved = 1'b0;
    if (!rst_n) begin
      under_code    <= 32'h8000_0000;
      over_code     <= 32'h7FFF_FFFF;
      mode_unsigned <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_UNDERLOAD: under_code <= cfg_data;
          CFG_OVERLOAD:  over_code <= cfg_data;
          CFG_UNSIGNED:  mode_unsigned <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        moved = 1'b1;
        valid = (int'(in_module_req) < MOD_COUNT) && (int'(in_pixel_index) < PIX_PER_MOD);
        addr = int'(in_module_req) * PIX_PER_MOD + int'(in_pixel_index);
        cur = (valid && pixel_sums.exists(addr)) ? pixel_sums[addr] : 32'h0;
        if (in_action == ACT_READOUT) begin
          res.sum_value = cur;
          res.preview_value = preview_of(cur);
          if (row_typed) begin
            res.sum_value = row_sum;
            res.preview_value = row_prev;
          end
          pending_readouts.push_back(res);
          if (valid) pixel_sums[addr] = 32'h0;
        end else if (valid) begin
          pixel_sums[addr] = accumulate_sum(cur, in_sample);
        end
      end
      if (out_pop && !out_empty) begin
        moved = 1'b1;
        if (pending_readouts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected item, sum %h", $realtime, out_sum_value);
        end else begin
          res = pending_readouts.pop_front();
          if (out_sum_value !== res.sum_value)
            report_mismatch("sum_value", res.sum_value, out_sum_value);
          if (out_preview_value !== res.preview_value)
            report_mismatch("preview_value", {16'h0, res.preview_value},
                            {16'h0, out_preview_value});
        end
      end
    end
    // Restart the stall count on any accepted item or taken result
    stall_cycles <= moved ? 0 : stall_cycles + 1;
  end

  // Result side: random pops, with a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("sticky_saturating_frame_summer regression: fail");
    $finish;
  end

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(logic action, logic mod_sel, logic [18:0] pixel,
                           logic [15:0] sample, logic typed, logic [31:0] exp_sum,
                           logic [15:0] exp_prev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push        <= 1'b1;
    in_action      <= action;
    in_module_req  <= mod_sel;
    in_pixel_index <= pixel;
    in_sample      <= sample;
    row_typed      <= typed;
    row_sum        <= exp_sum;
    row_prev       <= exp_prev;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // Stop sending, wait for every readout, then let the pipe settle
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers on consecutive cycles
  task automatic program_regs(logic [31:0] under, logic [31:0] over, logic uns);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_UNDERLOAD;
    cfg_data  <= under;
    @(posedge clk);
    cfg_index <= CFG_OVERLOAD;
    cfg_data  <= over;
    @(posedge clk);
    cfg_index <= CFG_UNSIGNED;
    cfg_data  <= {31'b0, uns};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    logic [31:0] ph_under [PHASES];
    logic [31:0] ph_over [PHASES];
    logic        ph_uns [PHASES];
    logic [19:0] addr_pool [8];
    logic [19:0] addr;
    logic        action;

    // Hold reset, then let the clearing pass run behind in_full
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 36;
    recv_idle_pct = 71;
    foreach (DIRECTED_ROWS[i])
      send_item(DIRECTED_ROWS[i].action, DIRECTED_ROWS[i].mod_sel, DIRECTED_ROWS[i].pixel,
                DIRECTED_ROWS[i].sample, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].exp_sum,
                DIRECTED_ROWS[i].exp_prev);
    drain();

    // Small marker codes make sums land on a marker by accumulation
    ph_under = '{32'hFFFF_F448, $urandom(), 32'h7FFF_FFFF, 32'h0,
                 32'(int'($urandom_range(4000)) - 2000), 32'h8000_0000};
    ph_over  = '{32'd3000, 32'd20000, 32'h8000_0000, 32'd1000,
                 32'($urandom_range(3000)), 32'h7FFF_FFFF};
    ph_uns   = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};

    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct = (p < 2) ? 36 : (p < 4) ? 71 : 0;
      recv_idle_pct = (p < 2) ? 71 : (p < 4) ? 36 : 0;
      program_regs(ph_under[p], ph_over[p], ph_uns[p]);
      if (p == 2) hold_reqs++;
      // Mostly revisit a few pixels so sums grow and markers stick
      addr_pool[0] = 20'h00000;
      addr_pool[1] = 20'hFFFFF;
      for (int k = 2; k < 8; k++) addr_pool[k] = 20'($urandom());
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        action = ($urandom_range(99) < 35) ? ACT_READOUT : ACT_ACCUM;
        addr = ($urandom_range(99) < 85) ? addr_pool[$urandom_range(7)] : 20'($urandom());
        send_item(action, addr[19], addr[18:0], pick_sample(), 1'b0, 32'h0, 16'h0);
      end
      drain();
    end

    mismatches += pending_readouts.size();
    if (mismatches == 0) begin
      $display("sticky_saturating_frame_summer regression: pass");
    end else begin
      $display("sticky_saturating_frame_summer regression: fail");
    end
    $finish;
  end

endmodule
